// ===== hw/rtl/xtcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XTC coordinate decompressor package
// Shared constants, the magic size table and the divider request types.
// ----------------------------------------------------------------------------
package xtcd_pkg;

  localparam logic [24:0] MaxAtoms   = 25'd16777216;
  localparam logic [6:0]  FirstIndex = 7'd9;
  localparam logic [6:0]  LastIndex  = 7'd72;

  typedef struct packed {
    logic        start;
    logic [23:0] rem;
    logic [7:0]  dividend;
    logic [24:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  quot;
    logic [23:0] rem;
  } div_rsp_t;

  function automatic logic [24:0] magic_size(logic [6:0] idx);
    logic [24:0] m;
    case (idx)
      7'd9:  m = 25'd8;
      7'd10: m = 25'd10;
      7'd11: m = 25'd12;
      7'd12: m = 25'd16;
      7'd13: m = 25'd20;
      7'd14: m = 25'd25;
      7'd15: m = 25'd32;
      7'd16: m = 25'd40;
      7'd17: m = 25'd50;
      7'd18: m = 25'd64;
      7'd19: m = 25'd80;
      7'd20: m = 25'd101;
      7'd21: m = 25'd128;
      7'd22: m = 25'd161;
      7'd23: m = 25'd203;
      7'd24: m = 25'd256;
      7'd25: m = 25'd322;
      7'd26: m = 25'd406;
      7'd27: m = 25'd512;
      7'd28: m = 25'd645;
      7'd29: m = 25'd812;
      7'd30: m = 25'd1024;
      7'd31: m = 25'd1290;
      7'd32: m = 25'd1625;
      7'd33: m = 25'd2048;
      7'd34: m = 25'd2580;
      7'd35: m = 25'd3250;
      7'd36: m = 25'd4096;
      7'd37: m = 25'd5060;
      7'd38: m = 25'd6501;
      7'd39: m = 25'd8192;
      7'd40: m = 25'd10321;
      7'd41: m = 25'd13003;
      7'd42: m = 25'd16384;
      7'd43: m = 25'd20642;
      7'd44: m = 25'd26007;
      7'd45: m = 25'd32768;
      7'd46: m = 25'd41285;
      7'd47: m = 25'd52015;
      7'd48: m = 25'd65536;
      7'd49: m = 25'd82570;
      7'd50: m = 25'd104031;
      7'd51: m = 25'd131072;
      7'd52: m = 25'd165140;
      7'd53: m = 25'd208063;
      7'd54: m = 25'd262144;
      7'd55: m = 25'd330280;
      7'd56: m = 25'd416127;
      7'd57: m = 25'd524287;
      7'd58: m = 25'd660561;
      7'd59: m = 25'd832255;
      7'd60: m = 25'd1048576;
      7'd61: m = 25'd1321122;
      7'd62: m = 25'd1664510;
      7'd63: m = 25'd2097152;
      7'd64: m = 25'd2642245;
      7'd65: m = 25'd3329021;
      7'd66: m = 25'd4194304;
      7'd67: m = 25'd5284491;
      7'd68: m = 25'd6658042;
      7'd69: m = 25'd8388607;
      7'd70: m = 25'd10568983;
      7'd71: m = 25'd13316085;
      7'd72: m = 25'd16777216;
      default: m = 25'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/xtcd_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XTC byte divider
// Restoring divider that divides (rem * 256 + byte) by a divisor, one
// quotient bit per cycle, eight quotient bits per request.
// ----------------------------------------------------------------------------
module xtcd_divider
  import xtcd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [2:0]  cnt_q;
  logic [24:0] r_q;
  logic [7:0]  q_q;
  logic [7:0]  byte_q;
  logic [24:0] d_q;

  logic [25:0] trial;
  logic        fits;
  logic [25:0] diff;

  assign trial = {r_q, byte_q[7]};
  assign fits  = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd7;
        r_q    <= {1'b0, req_i.rem};
        byte_q <= req_i.dividend;
        d_q    <= req_i.divisor;
      end else if (busy_q) begin
        r_q    <= fits ? diff[24:0] : trial[24:0];
        q_q    <= {q_q[6:0], fits};
        byte_q <= {byte_q[6:0], 1'b0};
        cnt_q  <= cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q[23:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("Divider started while busy.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("Divider done without a running division.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (r_q < d_q))
    else $error("Divider remainder not below divisor.");

endmodule
`default_nettype wire

// ===== hw/rtl/xtc_coordinate_decompressor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// XTC coordinate decompressor
// Decodes the compressed coordinate body of one frame, one byte per
// transaction, into integer lattice coordinates.
// ----------------------------------------------------------------------------
// One byte is taken per input transaction, and the next byte is taken only
// after every result that this byte caused has been delivered from a
// two-entry result buffer. Every byte of a mixed-radix triple goes through
// the shared eight-step byte divider for the z and y axes; the x axis is
// assembled from the last quotients. A byte that only fills the bit
// reservoir needs no division.
// After any write to a range register the first byte that reaches a big
// triple also recomputes the triple geometry with a bit-length counter and,
// unless a range is 2^24 or wider, the shared multiplier, once per write.
module xtc_coordinate_decompressor_top
  import xtcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        start_frame_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      coord_x_o,
  output logic [31:0]      coord_y_o,
  output logic [31:0]      coord_z_o,
  output logic [23:0]      atom_number_o,
  output logic             frame_done_o,
  output logic             last_of_item_o
);

  typedef enum logic [3:0] {
    CFG_MIN_X = 4'd0,
    CFG_MIN_Y = 4'd1,
    CFG_MIN_Z = 4'd2,
    CFG_MAX_X = 4'd3,
    CFG_MAX_Y = 4'd4,
    CFG_MAX_Z = 4'd5,
    CFG_START_IDX = 4'd6,
    CFG_ATOM_TOTAL = 4'd7
  } cfg_e;

  typedef enum logic [2:0] {
    PH_BIG, PH_FLAG, PH_RUN, PH_GROUP, PH_SMALL, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {STEP_DN, STEP_ZERO, STEP_UP} step_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RUN, ST_MUL2, ST_MUL3, ST_MUL4, ST_BITLEN, ST_DIV_START,
    ST_DIV_WAIT, ST_BIG_END, ST_SMALL_END, ST_EMIT_PREV, ST_OUT
  } state_e;

  function automatic logic [6:0] divmod3(logic [4:0] v);
    logic [2:0] r;
    logic [2:0] t;
    logic [4:0] q;
    r = '0;
    q = '0;
    for (int k = 4; k >= 0; k--) begin
      t = {r[1:0], v[k]};
      q[k] = t >= 3'd3;
      r = (t >= 3'd3) ? t - 3'd3 : t;
    end
    return {q, r[1:0]};
  endfunction

  logic [31:0] min_q [3];
  logic [31:0] max_q [3];
  logic [6:0]  ssi_q;
  logic [24:0] total_q;

  logic        geom_valid_q;
  logic [6:0]  mix_q;
  logic [5:0]  w_q [3];
  logic [47:0] mul_q;
  logic [23:0] phi_q;
  logic [47:0] lo_q;
  logic [48:0] bl_val_q;
  logic [6:0]  bl_cnt_q;
  logic [1:0]  bl_axis_q;

  state_e      state_q;
  phase_e      phase_q;
  step_e       step_q;
  logic [63:0] res_q;
  logic [6:0]  held_q;
  logic [7:0]  radix_q [9];
  logic [31:0] prev_q [3];
  logic [31:0] hb_q [3];
  logic [4:0]  run_q;
  logic [6:0]  idx_q;
  logic [23:0] sh_q;
  logic [23:0] ssh_q;
  logic [24:0] emitted_q;
  logic [3:0]  part_q;
  logic [3:0]  pend_q;
  logic        first_q;
  logic [1:0]  ax_q;
  logic [3:0]  j_q;
  logic [23:0] drem_q;

  logic [31:0] slot_c_q [2][3];
  logic [23:0] slot_atom_q [2];
  logic        slot_done_q [2];
  logic [1:0]  n_q;
  logic        rd_q;

  logic [31:0] s_sz [3];
  logic        wide;
  logic [24:0] eff_total;
  logic [6:0]  tb;
  logic [7:0]  nb_sum;
  logic [3:0]  nb;
  logic [6:0]  rem_bits;
  logic [5:0]  cw;
  logic [5:0]  rd_n;
  logic        rd_ok;
  logic [6:0]  rd_shift;
  logic [63:0] rd_mask;
  logic [63:0] rd_full;
  logic [31:0] rd_val;
  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] mul_p;
  logic [48:0] hi_sum;
  logic [31:0] small_c [3];
  logic        em_req;
  logic        em_ok;
  logic [31:0] em_c [3];
  logic [6:0]  ad_idx;
  logic [23:0] ad_sh;
  logic [23:0] ad_ssh;
  logic [6:0]  cidx;
  logic [24:0] c_m0;
  logic [24:0] c_m1;
  logic [24:0] a_m;
  logic [6:0]  run_dm;
  logic [6:0]  pend_dm;
  logic [31:0] asm0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic        clr;
  phase_e      base_phase;
  logic [6:0]  base_held;
  logic [63:0] base_res;
  logic        append;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  xtcd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sz[i]    = max_q[i] - min_q[i] + 32'd1;
      small_c[i] = hb_q[i] + prev_q[i] - {8'd0, sh_q};
    end
    wide = |(s_sz[0][31:24] | s_sz[1][31:24] | s_sz[2][31:24]);
    eff_total = (total_q > MaxAtoms) ? MaxAtoms : total_q;

    tb       = (phase_q == PH_SMALL) ? idx_q : mix_q;
    nb_sum   = {1'b0, tb} + 8'd7;
    nb       = nb_sum[6:3];
    rem_bits = tb - {part_q[3:0], 3'b000};
    cw       = (rem_bits > 7'd8) ? 6'd8 : rem_bits[5:0];

    case (phase_q)
      PH_BIG:   rd_n = (mix_q != 7'd0) ? cw : w_q[part_q[1:0]];
      PH_FLAG:  rd_n = 6'd1;
      PH_RUN:   rd_n = 6'd5;
      PH_SMALL: rd_n = cw;
      default:  rd_n = 6'd0;
    endcase
    rd_ok    = held_q >= {1'b0, rd_n};
    rd_shift = held_q - {1'b0, rd_n};
    rd_mask  = (64'd1 << rd_n) - 64'd1;
    rd_full  = (res_q >> rd_shift) & rd_mask;
    rd_val   = rd_full[31:0];

    case (state_q)
      ST_MUL2: begin
        mul_a = mul_q[23:0];
        mul_b = s_sz[2][23:0];
      end
      ST_MUL3: begin
        mul_a = phi_q;
        mul_b = s_sz[2][23:0];
      end
      default: begin
        mul_a = s_sz[0][23:0];
        mul_b = s_sz[1][23:0];
      end
    endcase
    mul_p  = mul_a * mul_b;
    hi_sum = {1'b0, mul_q} + {25'd0, lo_q[47:24]};

    em_req = 1'b0;
    em_c   = hb_q;
    case (state_q)
      ST_RUN: em_req = (phase_q == PH_GROUP) && (run_q == 5'd0) && (n_q < 2'd2)
                       && (emitted_q < eff_total);
      ST_SMALL_END: begin
        em_req = 1'b1;
        em_c   = small_c;
      end
      ST_EMIT_PREV: begin
        em_req = 1'b1;
        em_c   = prev_q;
      end
      default: em_req = 1'b0;
    endcase
    em_ok = em_req && (emitted_q < eff_total) && (n_q < 2'd2);

    ad_idx = idx_q;
    ad_sh  = sh_q;
    ad_ssh = ssh_q;
    a_m    = magic_size(idx_q + 7'd1);
    if (step_q == STEP_DN && idx_q >= FirstIndex + 7'd1) begin
      a_m    = magic_size(idx_q - 7'd2);
      ad_idx = idx_q - 7'd1;
      ad_sh  = ssh_q;
      ad_ssh = (idx_q - 7'd1 > FirstIndex) ? a_m[24:1] : 24'd0;
    end else if (step_q == STEP_UP && idx_q <= LastIndex - 7'd1) begin
      ad_idx = idx_q + 7'd1;
      ad_ssh = sh_q;
      ad_sh  = a_m[24:1];
    end

    if (ssi_q < FirstIndex) begin
      cidx = FirstIndex;
    end else if (ssi_q > LastIndex) begin
      cidx = LastIndex;
    end else begin
      cidx = ssi_q;
    end
    c_m0 = magic_size(cidx);
    c_m1 = magic_size((cidx == FirstIndex) ? FirstIndex : cidx - 7'd1);

    run_dm  = divmod3(rd_val[4:0]);
    pend_dm = divmod3(run_q);

    b1   = (nb > 4'd1) ? radix_q[1] : 8'd0;
    b2   = (nb > 4'd2) ? radix_q[2] : 8'd0;
    b3   = (nb > 4'd3) ? radix_q[3] : 8'd0;
    asm0 = {b3, b2, b1, div_rsp.quot};

    clr        = start_frame_i;
    base_phase = clr ? PH_BIG : phase_q;
    base_held  = clr ? 7'd0 : held_q;
    base_res   = clr ? 64'd0 : res_q;
    append     = (base_phase != PH_DONE) && (base_held <= 7'd56);

    div_req.start    = state_q == ST_DIV_START;
    div_req.rem      = drem_q;
    div_req.dividend = radix_q[j_q];
    div_req.divisor  = (phase_q == PH_SMALL) ? magic_size(idx_q)
                                             : {1'b0, s_sz[ax_q][23:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        min_q[i]  <= '0;
        max_q[i]  <= '0;
        prev_q[i] <= '0;
        hb_q[i]   <= '0;
        w_q[i]    <= '0;
      end
      ssi_q        <= 7'd9;
      total_q      <= 25'd10;
      geom_valid_q <= 1'b0;
      mix_q        <= '0;
      bl_val_q     <= '0;
      bl_cnt_q     <= '0;
      bl_axis_q    <= '0;
      state_q      <= ST_IDLE;
      phase_q      <= PH_BIG;
      step_q       <= STEP_ZERO;
      res_q        <= '0;
      held_q       <= '0;
      run_q        <= '0;
      idx_q        <= FirstIndex;
      sh_q         <= 24'd4;
      ssh_q        <= 24'd4;
      emitted_q    <= '0;
      part_q       <= '0;
      pend_q       <= '0;
      first_q      <= 1'b0;
      ax_q         <= '0;
      j_q          <= '0;
      drem_q       <= '0;
      n_q          <= '0;
      rd_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_X: min_q[0] <= cfg_data_i;
          CFG_MIN_Y: min_q[1] <= cfg_data_i;
          CFG_MIN_Z: min_q[2] <= cfg_data_i;
          CFG_MAX_X: max_q[0] <= cfg_data_i;
          CFG_MAX_Y: max_q[1] <= cfg_data_i;
          CFG_MAX_Z: max_q[2] <= cfg_data_i;
          CFG_START_IDX: ssi_q <= cfg_data_i[6:0];
          CFG_ATOM_TOTAL: total_q <= cfg_data_i[24:0];
          default: ssi_q <= ssi_q;
        endcase
        if (cfg_index_i <= CFG_MAX_Z) begin
          geom_valid_q <= 1'b0;
        end
      end

      if (em_ok) begin
        slot_c_q[n_q[0]]    <= em_c;
        slot_atom_q[n_q[0]] <= emitted_q[23:0];
        slot_done_q[n_q[0]] <= (emitted_q + 25'd1) == eff_total;
        emitted_q           <= emitted_q + 25'd1;
        n_q                 <= n_q + 2'd1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            res_q  <= append ? {base_res[55:0], byte_in_i} : base_res;
            held_q <= append ? base_held + 7'd8 : base_held;
            if (clr) begin
              for (int i = 0; i < 3; i++) begin
                prev_q[i] <= '0;
                hb_q[i]   <= '0;
              end
              run_q     <= '0;
              idx_q     <= cidx;
              sh_q      <= c_m0[24:1];
              ssh_q     <= c_m1[24:1];
              emitted_q <= '0;
              pend_q    <= '0;
              first_q   <= 1'b0;
              step_q    <= STEP_ZERO;
              part_q    <= '0;
              phase_q   <= PH_BIG;
            end
            n_q     <= '0;
            rd_q    <= 1'b0;
            state_q <= ST_RUN;
          end
        end

        ST_RUN: begin
          if (phase_q == PH_DONE) begin
            state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
          end else if (emitted_q >= eff_total) begin
            phase_q <= PH_DONE;
            state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
          end else begin
            case (phase_q)
              PH_BIG: begin
                if (!geom_valid_q) begin
                  if (wide) begin
                    bl_val_q  <= {17'd0, s_sz[0]};
                    bl_cnt_q  <= '0;
                    bl_axis_q <= 2'd0;
                    state_q   <= ST_BITLEN;
                  end else begin
                    mul_q   <= mul_p;
                    state_q <= ST_MUL2;
                  end
                end else if (mix_q != 7'd0) begin
                  if (part_q < nb) begin
                    if (rd_ok) begin
                      radix_q[part_q] <= rd_val[7:0];
                      part_q          <= part_q + 4'd1;
                      held_q          <= rd_shift;
                    end else begin
                      state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
                    end
                  end else begin
                    ax_q    <= 2'd2;
                    j_q     <= nb - 4'd1;
                    drem_q  <= '0;
                    state_q <= ST_DIV_START;
                  end
                end else if (part_q < 4'd3) begin
                  if (rd_ok) begin
                    hb_q[part_q[1:0]] <= rd_val;
                    part_q            <= part_q + 4'd1;
                    held_q            <= rd_shift;
                  end else begin
                    state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
                  end
                end else begin
                  for (int i = 0; i < 3; i++) begin
                    hb_q[i] <= hb_q[i] + min_q[i];
                  end
                  part_q  <= '0;
                  phase_q <= PH_FLAG;
                end
              end
              PH_FLAG: begin
                if (rd_ok) begin
                  held_q <= rd_shift;
                  if (rd_val[0]) begin
                    phase_q <= PH_RUN;
                  end else begin
                    step_q  <= STEP_ZERO;
                    phase_q <= PH_GROUP;
                  end
                end else begin
                  state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
                end
              end
              PH_RUN: begin
                if (rd_ok) begin
                  held_q <= rd_shift;
                  run_q  <= rd_val[4:0] - {3'd0, run_dm[1:0]};
                  case (run_dm[1:0])
                    2'd0:    step_q <= STEP_DN;
                    2'd1:    step_q <= STEP_ZERO;
                    default: step_q <= STEP_UP;
                  endcase
                  phase_q <= PH_GROUP;
                end else begin
                  state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
                end
              end
              PH_GROUP: begin
                if (run_q != 5'd0) begin
                  prev_q  <= hb_q;
                  pend_q  <= pend_dm[5:2];
                  first_q <= 1'b1;
                  part_q  <= '0;
                  phase_q <= PH_SMALL;
                end else if (n_q >= 2'd2) begin
                  state_q <= ST_OUT;
                end else begin
                  prev_q  <= hb_q;
                  idx_q   <= ad_idx;
                  sh_q    <= ad_sh;
                  ssh_q   <= ad_ssh;
                  part_q  <= '0;
                  phase_q <= PH_BIG;
                end
              end
              PH_SMALL: begin
                if (part_q < nb) begin
                  if (rd_ok) begin
                    radix_q[part_q] <= rd_val[7:0];
                    part_q          <= part_q + 4'd1;
                    held_q          <= rd_shift;
                  end else begin
                    state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
                  end
                end else if (({1'b0, n_q} + (first_q ? 3'd2 : 3'd1)) > 3'd2) begin
                  state_q <= ST_OUT;
                end else begin
                  ax_q    <= 2'd2;
                  j_q     <= nb - 4'd1;
                  drem_q  <= '0;
                  state_q <= ST_DIV_START;
                end
              end
              default: begin
                phase_q <= PH_DONE;
                state_q <= (n_q == 2'd0) ? ST_IDLE : ST_OUT;
              end
            endcase
          end
        end

        ST_MUL2: begin
          phi_q   <= mul_q[47:24];
          mul_q   <= mul_p;
          state_q <= ST_MUL3;
        end

        ST_MUL3: begin
          lo_q    <= mul_q;
          mul_q   <= mul_p;
          state_q <= ST_MUL4;
        end

        ST_MUL4: begin
          if (hi_sum != 49'd0) begin
            bl_val_q <= hi_sum;
            bl_cnt_q <= 7'd24;
          end else begin
            bl_val_q <= {25'd0, lo_q[23:0]};
            bl_cnt_q <= '0;
          end
          bl_axis_q <= 2'd3;
          state_q   <= ST_BITLEN;
        end

        ST_BITLEN: begin
          if (bl_val_q != 49'd0) begin
            bl_val_q <= bl_val_q >> 1;
            bl_cnt_q <= bl_cnt_q + 7'd1;
          end else if (bl_axis_q == 2'd3) begin
            mix_q <= bl_cnt_q;
            for (int i = 0; i < 3; i++) begin
              w_q[i] <= '0;
            end
            geom_valid_q <= 1'b1;
            state_q      <= ST_RUN;
          end else begin
            w_q[bl_axis_q] <= bl_cnt_q[5:0];
            if (bl_axis_q == 2'd2) begin
              mix_q        <= '0;
              geom_valid_q <= 1'b1;
              state_q      <= ST_RUN;
            end else begin
              bl_axis_q <= bl_axis_q + 2'd1;
              bl_val_q  <= {17'd0, s_sz[bl_axis_q + 2'd1]};
              bl_cnt_q  <= '0;
            end
          end
        end

        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            radix_q[j_q] <= div_rsp.quot;
            if (j_q != 4'd0) begin
              j_q     <= j_q - 4'd1;
              drem_q  <= div_rsp.rem;
              state_q <= ST_DIV_START;
            end else begin
              hb_q[ax_q] <= {8'd0, div_rsp.rem};
              if (ax_q == 2'd2) begin
                ax_q    <= 2'd1;
                j_q     <= nb - 4'd1;
                drem_q  <= '0;
                state_q <= ST_DIV_START;
              end else begin
                hb_q[0] <= asm0;
                state_q <= (phase_q == PH_SMALL) ? ST_SMALL_END : ST_BIG_END;
              end
            end
          end
        end

        ST_BIG_END: begin
          for (int i = 0; i < 3; i++) begin
            hb_q[i] <= hb_q[i] + min_q[i];
          end
          part_q  <= '0;
          phase_q <= PH_FLAG;
          state_q <= ST_RUN;
        end

        ST_SMALL_END: begin
          hb_q <= small_c;
          if (first_q) begin
            state_q <= ST_EMIT_PREV;
          end else begin
            prev_q <= small_c;
            pend_q <= pend_q - 4'd1;
            part_q <= '0;
            if (pend_q == 4'd1) begin
              idx_q   <= ad_idx;
              sh_q    <= ad_sh;
              ssh_q   <= ad_ssh;
              phase_q <= PH_BIG;
            end else begin
              phase_q <= PH_SMALL;
            end
            state_q <= ST_RUN;
          end
        end

        ST_EMIT_PREV: begin
          first_q <= 1'b0;
          prev_q  <= hb_q;
          pend_q  <= pend_q - 4'd1;
          part_q  <= '0;
          if (pend_q == 4'd1) begin
            idx_q   <= ad_idx;
            sh_q    <= ad_sh;
            ssh_q   <= ad_ssh;
            phase_q <= PH_BIG;
          end else begin
            phase_q <= PH_SMALL;
          end
          state_q <= ST_RUN;
        end

        ST_OUT: begin
          if (!out_stall_i) begin
            if (last_of_item_o) begin
              state_q <= ST_IDLE;
            end else begin
              rd_q <= 1'b1;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = state_q == ST_OUT;
  assign coord_x_o      = slot_c_q[rd_q][0];
  assign coord_y_o      = slot_c_q[rd_q][1];
  assign coord_z_o      = slot_c_q[rd_q][2];
  assign atom_number_o  = slot_atom_q[rd_q];
  assign frame_done_o   = slot_done_q[rd_q];
  assign last_of_item_o = {1'b0, rd_q} == (n_q - 2'd1);

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= 7'd64)
    else $error("Bit reservoir count exceeds its width.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> ({1'b0, rd_q} < n_q))
    else $error("Result read beyond the filled buffer.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !out_stall_i && last_of_item_o |=> !out_valid_o)
    else $error("Result presented after the last of the byte.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_DIV_WAIT && phase_q == PH_BIG) |-> geom_valid_q)
    else $error("Big triple split without valid geometry.");

endmodule
`default_nettype wire
